>>> design/exact_price_order_matcher_core_macros.svh
// Assertion macros for the order matcher checker.
`ifndef EXACT_PRICE_ORDER_MATCHER_CORE_MACROS_SVH
`define EXACT_PRICE_ORDER_MATCHER_CORE_MACROS_SVH
// checked only while out of reset
`define EPOM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define EPOM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> design/epom_pkg.sv
// Shared codes of the order matcher.
`default_nettype none
package epom_pkg;
    localparam logic [1:0] KIND_TRADE      = 2'd0;
    localparam logic [1:0] KIND_SUBMIT_ACK = 2'd1;
    localparam logic [1:0] KIND_CANCEL_ACK = 2'd2;
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_UNKNOWN      = 2'd1;
    localparam logic [1:0] ST_NOT_OWNER    = 2'd2;
    localparam logic [1:0] ST_BOOK_FULL    = 2'd3;
    localparam logic       FUNC_SUBMIT     = 1'b0;
    localparam logic       FUNC_CANCEL     = 1'b1;
endpackage
`default_nettype wire

>>> design/exact_price_order_matcher_core.sv
// A submit scans the order table for a resting match before each fill and, if quantity remains,
// scans it once more for a free slot; a cancel scans it for the order id. One request at a time:
// each search walks the order table one slot per cycle through a single shared compare unit.
// Reset (synchronous, active low) empties the table (valid bits) and sets the next id to one.
// No clearing pass is needed.
`default_nettype none
module exact_price_order_matcher_core
    import epom_pkg::*;
#(
    parameter int TABLE_SLOTS      = 32,
    parameter int INSTRUMENT_COUNT = 16,
    parameter int OWNER_BITS       = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_func,
    input  wire         s_side,
    input  wire  [3:0]  s_instrument,
    input  wire  [31:0] s_quantity,
    input  wire  [31:0] s_limit_price,
    input  wire  [OWNER_BITS-1:0] s_owner_id,
    input  wire  [31:0] s_cancel_id,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_order_id,
    output logic [1:0]  m_status,
    output logic [31:0] m_fill_qty,
    output logic [31:0] m_fill_price,
    output logic [OWNER_BITS-1:0] m_buyer,
    output logic [OWNER_BITS-1:0] m_seller,
    output logic [3:0]  m_trade_instrument,
    output logic        m_last
);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [3:0] INST_MAX = 4'((INSTRUMENT_COUNT > 16 ? 16 : INSTRUMENT_COUNT) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_FILL, S_FREE, S_EMIT, S_CANCEL
    } state_t;

    state_t state_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [31:0] oid_mem  [TABLE_SLOTS];
    logic        side_mem [TABLE_SLOTS];
    logic [3:0]  inst_mem [TABLE_SLOTS];
    logic [31:0] price_mem[TABLE_SLOTS];
    logic [31:0] rem_mem  [TABLE_SLOTS];
    logic [OWNER_BITS-1:0] own_mem[TABLE_SLOTS];

    logic [31:0] id_ctr_reg, id_reg, rem_reg, price_reg, cid_reg, best_age_reg, srem_reg;
    logic        func_reg, side_reg, found_reg;
    logic [3:0]  inst_reg;
    logic [OWNER_BITS-1:0] owner_reg, sowner_reg;
    logic [CW-1:0] idx_reg, fills_reg;
    logic [IW-1:0] best_reg;

    // one shared compare unit on the current slot
    logic [IW-1:0] ix;
    logic          hit_match, hit_cancel;
    logic [31:0]   age;
    assign ix = idx_reg[IW-1:0];
    assign age = id_ctr_reg - oid_mem[ix];
    assign hit_match = valid_reg[ix] && side_mem[ix] == !side_reg && inst_mem[ix] == inst_reg
                       && price_mem[ix] == price_reg;
    assign hit_cancel = valid_reg[ix] && oid_mem[ix] == cid_reg;

    logic [31:0] q;
    assign q = (rem_reg < srem_reg) ? rem_reg : srem_reg;

    // a new result is loaded this cycle
    logic out_load;
    assign out_load = (state_reg == S_FILL || state_reg == S_EMIT) && (!m_valid || m_ready);

    assign s_ready = (state_reg == S_IDLE) && !m_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            id_ctr_reg <= 32'd1;
            m_valid    <= 1'b0;
        end else begin
            if (m_valid && m_ready && !out_load) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        func_reg  <= s_func;
                        side_reg  <= s_side;
                        inst_reg  <= (32'(s_instrument) >= INSTRUMENT_COUNT) ? INST_MAX
                                     : s_instrument;
                        rem_reg   <= s_quantity;
                        price_reg <= s_limit_price;
                        owner_reg <= s_owner_id;
                        cid_reg   <= s_cancel_id;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        fills_reg <= '0;
                        if (s_func == FUNC_CANCEL) begin
                            state_reg <= S_CANCEL;
                        end else begin
                            id_reg     <= id_ctr_reg;
                            id_ctr_reg <= id_ctr_reg + 32'd1;
                            state_reg  <= (s_quantity == 32'd0) ? S_EMIT : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit_match && (!found_reg || age > best_age_reg)) begin
                        found_reg    <= 1'b1;
                        best_reg     <= ix;
                        best_age_reg <= age;
                    end
                    if (idx_reg == CW'(TABLE_SLOTS - 1)) begin
                        state_reg <= S_READ;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_READ: begin
                    if (!found_reg || fills_reg == CW'(TABLE_SLOTS)) begin
                        idx_reg   <= '0;
                        state_reg <= S_FREE;
                    end else begin
                        srem_reg   <= rem_mem[best_reg];
                        sowner_reg <= own_mem[best_reg];
                        state_reg  <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (!m_valid || m_ready) begin
                        m_valid            <= 1'b1;
                        m_kind             <= KIND_TRADE;
                        m_order_id         <= id_reg;
                        m_status           <= ST_OK;
                        m_fill_qty         <= q;
                        m_fill_price       <= price_reg;
                        m_buyer            <= side_reg ? sowner_reg : owner_reg;
                        m_seller           <= side_reg ? owner_reg : sowner_reg;
                        m_trade_instrument <= inst_reg;
                        m_last             <= 1'b0;
                        rem_mem[best_reg]  <= srem_reg - q;
                        if (srem_reg == q) valid_reg[best_reg] <= 1'b0;
                        rem_reg   <= rem_reg - q;
                        fills_reg <= fills_reg + CW'(1);
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        if (rem_reg == q) begin
                            state_reg <= S_EMIT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_FREE: begin
                    if (!valid_reg[ix]) begin
                        valid_reg[ix] <= 1'b1;
                        oid_mem[ix]   <= id_reg;
                        side_mem[ix]  <= side_reg;
                        inst_mem[ix]  <= inst_reg;
                        price_mem[ix] <= price_reg;
                        rem_mem[ix]   <= rem_reg;
                        own_mem[ix]   <= owner_reg;
                        state_reg     <= S_EMIT;
                        rem_reg       <= '0;
                    end else if (idx_reg == CW'(TABLE_SLOTS - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_CANCEL: begin
                    if (hit_cancel) begin
                        found_reg <= 1'b1;
                        if (own_mem[ix] == owner_reg) valid_reg[ix] <= 1'b0;
                        state_reg <= S_EMIT;
                    end else if (idx_reg == CW'(TABLE_SLOTS - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid            <= 1'b1;
                        m_fill_qty         <= '0;
                        m_fill_price       <= '0;
                        m_buyer            <= '0;
                        m_seller           <= '0;
                        m_trade_instrument <= '0;
                        m_last             <= 1'b1;
                        if (func_reg == FUNC_CANCEL) begin
                            m_kind     <= KIND_CANCEL_ACK;
                            m_order_id <= cid_reg;
                            if (!found_reg) m_status <= ST_UNKNOWN;
                            else if (own_mem[ix] != owner_reg) m_status <= ST_NOT_OWNER;
                            else m_status <= ST_OK;
                        end else begin
                            m_kind     <= KIND_SUBMIT_ACK;
                            m_order_id <= id_reg;
                            m_status   <= (rem_reg != 32'd0) ? ST_BOOK_FULL : ST_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/epom_checker.sv
// Port-level checker for the order matcher, bound to the top level.
`default_nettype none
`include "exact_price_order_matcher_core_macros.svh"
module epom_checker
    import epom_pkg::*;
(
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [1:0] m_kind,
    input wire [1:0] m_status,
    input wire       m_last
);
    logic trade_out, ack_out;
    assign trade_out = m_valid && m_kind == KIND_TRADE;
    assign ack_out   = m_valid && m_kind != KIND_TRADE;

    `EPOM_ASSERT(a_busy_after_req, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "busy")
    `EPOM_ASSERT(a_trade_out, aclk, aresetn, trade_out |-> (!m_last && m_status == ST_OK), "trade")
    `EPOM_ASSERT(a_ack_last, aclk, aresetn, ack_out |-> m_last, "ack not last")
    `EPOM_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `EPOM_ASSERT_ALWAYS(a_reset_idle, aclk, (!aresetn) |=> !m_valid, "result during reset")
endmodule

bind exact_price_order_matcher_core epom_checker u_epom_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_status(m_status),
    .m_last(m_last)
);
`default_nettype wire
